// ===== src/imh_pkg.sv =====
// Package for the indexed min-heap block: widths, status codes, action codes
// and the request structures that drive the two RAMs. No dependencies.
package imh_pkg;

  localparam int MAX_KEYS = 1024;
  localparam int VALUE_BITS = 16;
  localparam int KEY_W = 10;
  localparam int IDX_W = $clog2(MAX_KEYS);
  localparam int CNT_W = IDX_W + 1;
  localparam int ENT_W = KEY_W + VALUE_BITS;
  localparam int SLOT_W = IDX_W + 1;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_POP = 2'd1;
  localparam logic [1:0] ACT_DEC = 2'd2;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_POP_EMPTY = 3'd1,
    ST_FULL = 3'd2,
    ST_KEY_PRESENT = 3'd3,
    ST_KEY_ABSENT = 3'd4,
    ST_VALUE_ZERO = 3'd5
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  // Present flag and heap slot of one key.
  typedef struct packed {
    logic present;
    logic [IDX_W-1:0] slot;
  } slot_t;

  typedef struct packed {
    logic we;
    logic [IDX_W-1:0] addr;
    entry_t wdata;
  } heap_req_t;

  typedef struct packed {
    logic we;
    logic [KEY_W-1:0] addr;
    slot_t wdata;
  } slot_req_t;

endpackage

// ===== src/imh_if.sv =====
// Valid/ready channel interfaces for the input and result words.
// Depends on imh_pkg.
interface imh_in_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [imh_pkg::KEY_W-1:0] item_key;
  logic [imh_pkg::VALUE_BITS-1:0] item_value;
  modport source (output valid, action, item_key, item_value, input ready);
  modport sink (input valid, action, item_key, item_value, output ready);
endinterface

interface imh_out_if;
  logic valid;
  logic ready;
  logic [imh_pkg::KEY_W-1:0] popped_key;
  logic [imh_pkg::VALUE_BITS-1:0] popped_value;
  logic [imh_pkg::KEY_W-1:0] top_key;
  logic [imh_pkg::VALUE_BITS-1:0] top_value;
  logic [imh_pkg::CNT_W-1:0] entry_total;
  logic [2:0] status;
  modport source (output valid, popped_key, popped_value, top_key, top_value,
                  entry_total, status, input ready);
  modport sink (input valid, popped_key, popped_value, top_key, top_value,
                entry_total, status, output ready);
endinterface

// ===== src/imh_ram.sv =====
// Generic single-port RAM with a registered read.
// No dependencies.
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== src/imh_ctrl.sv =====
// Sequencer of the heap: decodes the action, walks sift-up and sift-down one
// level at a time over the RAM ports, and holds the result word.
// Depends on imh_pkg and imh_if.
module imh_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  imh_in_if.sink               in_ch,
  imh_out_if.source            out_ch,
  output imh_pkg::heap_req_t   heap_req,
  input  imh_pkg::entry_t      heap_rdata,
  output imh_pkg::slot_req_t   slot_req,
  input  imh_pkg::slot_t       slot_rdata
);
  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_DECIDE = 14'b00000000000100,
    S_DEC    = 14'b00000000001000,
    S_POP0   = 14'b00000000010000,
    S_POP1   = 14'b00000000100000,
    S_UP     = 14'b00000001000000,
    S_UP_C   = 14'b00000010000000,
    S_DN     = 14'b00000100000000,
    S_DN_R   = 14'b00001000000000,
    S_DN_C   = 14'b00010000000000,
    S_PLACE  = 14'b00100000000000,
    S_TOP    = 14'b01000000000000,
    S_FIN    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] act_r, act_nxt;
  logic [imh_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [imh_pkg::VALUE_BITS-1:0] val_r, val_nxt;
  imh_pkg::entry_t cur_r, cur_nxt, left_r, left_nxt, pop_r, pop_nxt;
  logic [imh_pkg::IDX_W-1:0] idx_r, idx_nxt, clr_r, clr_nxt;
  logic [imh_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  imh_pkg::status_t status_r, status_nxt;
  logic out_valid_r, out_valid_nxt;
  imh_pkg::entry_t out_pop_r, out_pop_nxt, out_top_r, out_top_nxt;
  logic [imh_pkg::CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  imh_pkg::status_t out_status_r, out_status_nxt;

  logic accept;
  logic [imh_pkg::IDX_W-1:0] parent;
  logic [imh_pkg::CNT_W-1:0] last_pos;
  logic [imh_pkg::CNT_W:0] left_idx, right_idx;
  logic right_ok, take_right;
  imh_pkg::entry_t child;
  logic [imh_pkg::IDX_W-1:0] child_idx;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign parent = (idx_r - imh_pkg::IDX_W'(1)) >> 1;
  assign last_pos = cnt_r - imh_pkg::CNT_W'(1);
  assign left_idx = {1'b0, idx_r, 1'b1};
  assign right_idx = left_idx + (imh_pkg::CNT_W + 1)'(1);
  assign right_ok = right_idx < {1'b0, cnt_r};
  // The right child wins only on a strictly smaller value.
  assign take_right = right_ok && (heap_rdata.value < left_r.value);
  assign child = take_right ? heap_rdata : left_r;
  assign child_idx = take_right ? right_idx[imh_pkg::IDX_W-1:0]
                                : left_idx[imh_pkg::IDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r;
    key_nxt = key_r;
    val_nxt = val_r;
    cur_nxt = cur_r;
    left_nxt = left_r;
    pop_nxt = pop_r;
    idx_nxt = idx_r;
    clr_nxt = clr_r;
    cnt_nxt = cnt_r;
    status_nxt = status_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pop_nxt = out_pop_r;
    out_top_nxt = out_top_r;
    out_cnt_nxt = out_cnt_r;
    out_status_nxt = out_status_r;
    heap_req = '0;
    slot_req = '0;

    case (state_r)
      S_CLEAR: begin
        slot_req.we = 1'b1;
        slot_req.addr = clr_r;
        clr_nxt = clr_r + imh_pkg::IDX_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          act_nxt = in_ch.action;
          key_nxt = in_ch.item_key;
          val_nxt = in_ch.item_value;
          status_nxt = imh_pkg::ST_OK;
          pop_nxt = '0;
          slot_req.addr = in_ch.item_key;
          heap_req.addr = '0;
          case (in_ch.action)
            imh_pkg::ACT_INSERT, imh_pkg::ACT_DEC: state_nxt = S_DECIDE;
            imh_pkg::ACT_POP: state_nxt = S_POP0;
            default: state_nxt = S_TOP;
          endcase
        end
      end
      S_DECIDE: begin
        if (act_r == imh_pkg::ACT_INSERT) begin
          if (slot_rdata.present) begin
            status_nxt = imh_pkg::ST_KEY_PRESENT;
            state_nxt = S_TOP;
          end else if (cnt_r >= imh_pkg::CNT_W'(imh_pkg::MAX_KEYS)) begin
            status_nxt = imh_pkg::ST_FULL;
            state_nxt = S_TOP;
          end else begin
            cur_nxt = '{key: key_r, value: val_r};
            idx_nxt = cnt_r[imh_pkg::IDX_W-1:0];
            cnt_nxt = cnt_r + imh_pkg::CNT_W'(1);
            state_nxt = S_UP;
          end
        end else begin
          if (!slot_rdata.present) begin
            status_nxt = imh_pkg::ST_KEY_ABSENT;
            state_nxt = S_TOP;
          end else begin
            heap_req.addr = slot_rdata.slot;
            idx_nxt = slot_rdata.slot;
            state_nxt = S_DEC;
          end
        end
      end
      S_DEC: begin
        if (heap_rdata.value == '0) begin
          status_nxt = imh_pkg::ST_VALUE_ZERO;
          state_nxt = S_TOP;
        end else begin
          cur_nxt = '{key: heap_rdata.key,
                      value: heap_rdata.value - imh_pkg::VALUE_BITS'(1)};
          state_nxt = S_UP;
        end
      end
      S_POP0: begin
        if (cnt_r == '0) begin
          status_nxt = imh_pkg::ST_POP_EMPTY;
          state_nxt = S_TOP;
        end else begin
          heap_req.addr = last_pos[imh_pkg::IDX_W-1:0];
          pop_nxt = heap_rdata;
          state_nxt = S_POP1;
        end
      end
      S_POP1: begin
        // The popped key leaves the map; the last entry becomes the hole's
        // occupant and sinks from the root.
        slot_req.we = 1'b1;
        slot_req.addr = pop_r.key;
        cur_nxt = heap_rdata;
        cnt_nxt = cnt_r - imh_pkg::CNT_W'(1);
        idx_nxt = '0;
        state_nxt = (cnt_r == imh_pkg::CNT_W'(1)) ? S_TOP : S_DN;
      end
      S_UP: begin
        heap_req.addr = parent;
        state_nxt = (idx_r == '0) ? S_PLACE : S_UP_C;
      end
      S_UP_C: begin
        if (heap_rdata.value > cur_r.value) begin
          heap_req.we = 1'b1;
          heap_req.addr = idx_r;
          heap_req.wdata = heap_rdata;
          slot_req.we = 1'b1;
          slot_req.addr = heap_rdata.key;
          slot_req.wdata = '{present: 1'b1, slot: idx_r};
          idx_nxt = parent;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_DN: begin
        heap_req.addr = left_idx[imh_pkg::IDX_W-1:0];
        state_nxt = (left_idx >= {1'b0, cnt_r}) ? S_PLACE : S_DN_R;
      end
      S_DN_R: begin
        left_nxt = heap_rdata;
        heap_req.addr = right_idx[imh_pkg::IDX_W-1:0];
        state_nxt = S_DN_C;
      end
      S_DN_C: begin
        if (cur_r.value > child.value) begin
          heap_req.we = 1'b1;
          heap_req.addr = idx_r;
          heap_req.wdata = child;
          slot_req.we = 1'b1;
          slot_req.addr = child.key;
          slot_req.wdata = '{present: 1'b1, slot: idx_r};
          idx_nxt = child_idx;
          state_nxt = S_DN;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        heap_req.we = 1'b1;
        heap_req.addr = idx_r;
        heap_req.wdata = cur_r;
        slot_req.we = 1'b1;
        slot_req.addr = cur_r.key;
        slot_req.wdata = '{present: 1'b1, slot: idx_r};
        state_nxt = S_TOP;
      end
      S_TOP: begin
        heap_req.addr = '0;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_pop_nxt = pop_r;
          out_top_nxt = (cnt_r == '0) ? '0 : heap_rdata;
          out_cnt_nxt = cnt_r;
          out_status_nxt = status_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r <= act_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    cur_r <= cur_nxt;
    left_r <= left_nxt;
    pop_r <= pop_nxt;
    idx_r <= idx_nxt;
    status_r <= status_nxt;
    out_pop_r <= out_pop_nxt;
    out_top_r <= out_top_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.popped_key = out_pop_r.key;
  assign out_ch.popped_value = out_pop_r.value;
  assign out_ch.top_key = out_top_r.key;
  assign out_ch.top_value = out_top_r.value;
  assign out_ch.entry_total = out_cnt_r;
  assign out_ch.status = out_status_r;

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= imh_pkg::CNT_W'(imh_pkg::MAX_KEYS))
    else $error("entry count above capacity");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted word did not start work");
  a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UP_C |-> idx_r != '0)
    else $error("sift-up compare at the root");
  a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != imh_pkg::ST_OK) |->
      (out_pop_r.key == '0 && out_pop_r.value == '0))
    else $error("popped fields set on a failed action");
  a_clear_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ch.ready)
    else $error("input taken during map clearing");
`endif
endmodule

// ===== src/indexed_min_heap_decrement_core.sv =====
// Top level of the indexed min-heap: sequencer plus heap and key-map RAMs.
// Depends on imh_pkg, imh_if, imh_ram and imh_ctrl.
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    action, item_key, item_value
//  out_ch    out  valid/ready    popped/top key and value, entry_total, status
//
// After reset the key map is cleared entry by entry; no word is taken then.
// A rejected or unused action goes to its result without a heap walk; an
// accepted one walks sift-up or sift-down one level at a time (at most 10
// levels), as each level reads the single-port heap RAM.
// One word is worked at a time; the result register lets the next word be
// taken while a result waits, and a stalled result only holds the next finish.
module indexed_min_heap_decrement_core (
  input  logic       clk,
  input  logic       rst_n,
  imh_in_if.sink     in_ch,
  imh_out_if.source  out_ch
);
  imh_pkg::heap_req_t heap_req;
  imh_pkg::slot_req_t slot_req;
  imh_pkg::entry_t heap_rdata;
  imh_pkg::slot_t slot_rdata;

  imh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .heap_req   (heap_req),
    .heap_rdata (heap_rdata),
    .slot_req   (slot_req),
    .slot_rdata (slot_rdata)
  );

  imh_ram #(.WIDTH(imh_pkg::ENT_W), .DEPTH(imh_pkg::MAX_KEYS)) u_heap_ram (
    .clk   (clk),
    .we    (heap_req.we),
    .addr  (heap_req.addr),
    .wdata (heap_req.wdata),
    .rdata (heap_rdata)
  );

  imh_ram #(.WIDTH(imh_pkg::SLOT_W), .DEPTH(imh_pkg::MAX_KEYS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_req.we),
    .addr  (slot_req.addr),
    .wdata (slot_req.wdata),
    .rdata (slot_rdata)
  );
endmodule
